// ===== sv/lce_pkg.sv =====
// Shared types and constants for the protected-eviction LRU cache tag engine.
// Depends on nothing; every other file imports it.
package lce_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 6;
    localparam int OCC_W   = 6;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    // Operation codes carried in the command beat.
    typedef enum logic [2:0] {
        OP_LOOKUP  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_EVICT   = 3'd2,
        OP_SET_DRT = 3'd3,
        OP_CLR_DRT = 3'd4,
        OP_FLUSH   = 3'd5,
        OP_CLEAR   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic               dirty;
        logic               pinned;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    localparam entry_t ENTRY_EMPTY = '0;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [KEY_W-1:0] node_key;
        logic             pin_entry;
    } cmd_t;

    typedef struct packed {
        logic             hit;
        logic             done_ok;
        logic             write_back;
        logic             victim_valid;
        logic [KEY_W-1:0] out_key;
        logic             last_result;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

endpackage

// ===== sv/lce_cell.sv =====
// One slot of the entry chain: holds an entry and takes its right neighbor's on shift.
// Depends on lce_pkg.
module lce_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  lce_pkg::entry_t right_in,
    output lce_pkg::entry_t q
);
    import lce_pkg::*;

    logic   valid_reg;
    entry_t data_reg;

    // The valid mark is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= right_in.valid;
        end
    end

    // Key, marks and stamp are payload.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= right_in;
        end
    end

    always_comb
    begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

// ===== sv/lce_ctrl.sv =====
// Sequencer of the cache engine: rotates the cell chain, inspects the head entry,
// feeds the tail and produces result beats. Depends on lce_pkg.
module lce_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lce_pkg::cmd_t                cmd,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [lce_pkg::CAP_W-1:0]    cfg_data,
    input  lce_pkg::entry_t              head,
    input  lce_pkg::entry_t              second,
    output logic                         shift,
    output lce_pkg::entry_t              tail,
    output logic                         rsp_valid,
    output lce_pkg::rsp_t                rsp
);
    import lce_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [2:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic               pin_reg;
    logic               found_reg, found_next;
    logic               mdirty_reg, mdirty_next;
    logic               best_vld_reg, best_vld_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [KEY_W-1:0]   best_key_reg, best_key_next;
    logic               best_dirty_reg, best_dirty_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [KEY_W-1:0]   pend_key_reg, pend_key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [CAP_W-1:0]   cap_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               accept;
    logic               hmatch;
    logic               room;
    logic [CNT_W-1:0]   cap_eff;
    logic               is_flush;
    logic [CNT_W-1:0]   flush_occ;
    entry_t             new_entry;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign shift     = (state_reg == ST_SCAN) || (state_reg == ST_APPLY);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Effective capacity is the register clamped to one through the entry count.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (int'(cap_reg) > ENTRIES)
        begin
            cap_eff = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign room      = (count_reg < cap_eff);
    assign hmatch    = head.valid && (head.key == key_reg);
    assign is_flush  = (op_reg == OP_FLUSH) || (op_reg == OP_CLEAR);
    assign flush_occ = (op_reg == OP_CLEAR) ? '0 : count_reg;

    always_comb
    begin
        new_entry        = ENTRY_EMPTY;
        new_entry.valid  = 1'b1;
        new_entry.key    = key_reg;
        new_entry.pinned = pin_reg;
        new_entry.stamp  = stamp_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (j_reg == LAST)
                begin
                    state_next = (op_reg == OP_INSERT) ? ST_APPLY : ST_FINISH;
                end
            end
            ST_APPLY:
            begin
                if (j_reg == LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, tail feed and result beats.
    always_comb
    begin
        j_next          = (j_reg == LAST) ? '0 : j_reg + IDX_W'(1);
        found_next      = found_reg;
        mdirty_next     = mdirty_reg;
        best_vld_next   = best_vld_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_key_next   = best_key_reg;
        best_dirty_next = best_dirty_reg;
        pend_vld_next   = pend_vld_reg;
        pend_key_next   = pend_key_reg;
        count_next      = count_reg;
        stamp_next      = stamp_reg;
        rsp_valid_next  = 1'b0;
        rsp_next        = '0;
        tail            = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                j_next        = '0;
                found_next    = 1'b0;
                best_vld_next = 1'b0;
                pend_vld_next = 1'b0;
            end
            ST_SCAN:
            begin
                if (hmatch)
                begin
                    found_next  = 1'b1;
                    mdirty_next = head.dirty;
                end
                // Oldest unprotected entry; strict compare keeps the lowest slot on a tie.
                if (head.valid && !head.pinned &&
                    (!best_vld_reg || (head.stamp < best_stamp_reg)))
                begin
                    best_vld_next   = 1'b1;
                    best_idx_next   = j_reg;
                    best_stamp_next = head.stamp;
                    best_key_next   = head.key;
                    best_dirty_next = head.dirty;
                end
                // Each dirty entry is held until the next one is found so the final one can carry the last mark.
                if (is_flush && head.valid && head.dirty)
                begin
                    if (pend_vld_reg)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.done_ok     = 1'b1;
                        rsp_next.write_back  = 1'b1;
                        rsp_next.out_key     = pend_key_reg;
                        rsp_next.occupancy   = OCC_W'(flush_occ);
                    end
                    pend_vld_next = 1'b1;
                    pend_key_next = head.key;
                end
                unique case (op_reg)
                    OP_LOOKUP:
                    begin
                        if (hmatch)
                        begin
                            tail.stamp = stamp_reg;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (hmatch)
                        begin
                            tail.stamp  = stamp_reg;
                            tail.pinned = pin_reg;
                        end
                    end
                    OP_EVICT:
                    begin
                        // From the hit onward the chain closes the gap.
                        if (found_reg || hmatch)
                        begin
                            tail = (j_reg == LAST) ? ENTRY_EMPTY : second;
                        end
                    end
                    OP_SET_DRT, OP_CLR_DRT:
                    begin
                        if (hmatch)
                        begin
                            tail.dirty = (op_reg == OP_SET_DRT);
                        end
                    end
                    OP_FLUSH:
                    begin
                        tail.dirty = 1'b0;
                    end
                    OP_CLEAR:
                    begin
                        tail = ENTRY_EMPTY;
                    end
                    default:
                    begin
                        tail = head;
                    end
                endcase
            end
            ST_APPLY:
            begin
                // New key goes to the first free slot or over the victim.
                if (!found_reg)
                begin
                    if (room && ({1'b0, j_reg} == CNT_W'(count_reg)))
                    begin
                        tail = new_entry;
                    end
                    else if (!room && best_vld_reg && (j_reg == best_idx_reg))
                    begin
                        tail = new_entry;
                    end
                end
            end
            ST_FINISH:
            begin
                rsp_valid_next       = 1'b1;
                rsp_next.last_result = 1'b1;
                unique case (op_reg)
                    OP_LOOKUP, OP_SET_DRT, OP_CLR_DRT:
                    begin
                        rsp_next.hit     = found_reg;
                        rsp_next.done_ok = found_reg;
                        if (found_reg && (op_reg == OP_LOOKUP))
                        begin
                            stamp_next = stamp_reg + STAMP_W'(1);
                        end
                    end
                    OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.hit     = 1'b1;
                            rsp_next.done_ok = 1'b1;
                            stamp_next       = stamp_reg + STAMP_W'(1);
                        end
                        else if (room)
                        begin
                            rsp_next.done_ok = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                            stamp_next       = stamp_reg + STAMP_W'(1);
                        end
                        else if (best_vld_reg)
                        begin
                            rsp_next.done_ok      = 1'b1;
                            rsp_next.write_back   = best_dirty_reg;
                            rsp_next.victim_valid = 1'b1;
                            rsp_next.out_key      = best_key_reg;
                            stamp_next            = stamp_reg + STAMP_W'(1);
                        end
                    end
                    OP_EVICT:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.hit        = 1'b1;
                            rsp_next.done_ok    = 1'b1;
                            rsp_next.write_back = mdirty_reg;
                            rsp_next.out_key    = key_reg;
                            count_next          = count_reg - CNT_W'(1);
                        end
                    end
                    OP_FLUSH, OP_CLEAR:
                    begin
                        rsp_next.done_ok    = 1'b1;
                        rsp_next.write_back = pend_vld_reg;
                        rsp_next.out_key    = pend_vld_reg ? pend_key_reg : '0;
                        if (op_reg == OP_CLEAR)
                        begin
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        rsp_next.done_ok = 1'b0;
                    end
                endcase
                rsp_next.occupancy = OCC_W'(count_next);
            end
            default:
            begin
                tail = head;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            best_vld_reg  <= 1'b0;
            pend_vld_reg  <= 1'b0;
            count_reg     <= '0;
            stamp_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            found_reg     <= found_next;
            best_vld_reg  <= best_vld_next;
            pend_vld_reg  <= pend_vld_next;
            count_reg     <= count_next;
            stamp_reg     <= stamp_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.opcode;
            key_reg <= cmd.node_key;
            pin_reg <= cmd.pin_entry;
        end
        mdirty_reg     <= mdirty_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_key_reg   <= best_key_next;
        best_dirty_reg <= best_dirty_next;
        pend_key_reg   <= pend_key_next;
        rsp_reg        <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count exceeds the number of slots");

    a_finish_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (rsp_valid && rsp.last_result && !busy))
        else $error("finish did not produce the closing beat");

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg == ST_SCAN) && (j_reg == '0)))
        else $error("accepted command did not start a scan");

endmodule

// ===== sv/lru_cache_protected_evict_top.sv =====
// Each command runs a scan pass as the cell chain rotates once past the head; insert
// follows it with an apply pass. A closing state then produces the last result beat.
// A new command is accepted only while idle; busy drops when the last result beat appears.
// Flush and clear give one beat per dirty entry, or a single closing beat if none is dirty.
// Reset empties the cache, zeroes the stamp counter and sets the capacity to 32.
// Results cannot be stalled. Depends on lce_pkg, lce_cell and lce_ctrl.
module lru_cache_protected_evict_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  lce_pkg::cmd_t             cmd,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [lce_pkg::CAP_W-1:0] cfg_data,
    output logic                      rsp_valid,
    output lce_pkg::rsp_t             rsp
);
    import lce_pkg::*;

    entry_t chain [ENTRIES];
    entry_t tail;
    logic   shift;

    // Ring of cells; the last one is fed by the sequencer.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        if (i == ENTRIES - 1)
        begin : g_end
            lce_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .right_in (tail),
                .q        (chain[i])
            );
        end
        else
        begin : g_mid
            lce_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (shift),
                .right_in (chain[i+1]),
                .q        (chain[i])
            );
        end
    end

    lce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .head      (chain[0]),
        .second    (chain[1]),
        .shift     (shift),
        .tail      (tail),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
